// ----- src/rss_pkg.sv -----
// Shared types and constants for the reservoir sampler.
// No dependencies; imported by every module of the block.
package rss_pkg;

    localparam int RESERVOIR_DEPTH = 32;
    localparam int IDX_W   = (RESERVOIR_DEPTH > 1) ? $clog2(RESERVOIR_DEPTH) : 1;
    localparam int CNT_W   = $clog2(RESERVOIR_DEPTH + 1);
    localparam int SIZE_W  = 6;
    localparam int FIELD_W = 64;
    localparam int RND_W   = 32;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [ADDR_W-1:0] REG_RESERVOIR_SIZE = ADDR_W'(0);
    localparam logic [SIZE_W-1:0] SIZE_RESET         = SIZE_W'(32);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PICK,
        ST_SCAN,
        ST_SCAN_END,
        ST_LOAD,
        ST_OUT
    } rss_state_t;

    typedef struct packed {
        logic             start;
        logic [RND_W-1:0] dividend;
        logic [RND_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [RND_W-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic               clear;
        logic               cand_valid;
        logic [IDX_W-1:0]   cand_idx;
        logic               prev_valid;
        logic [FIELD_W-1:0] prev_ts;
        logic [FIELD_W-1:0] prev_id;
        logic [IDX_W-1:0]   prev_idx;
    } scan_ctrl_t;

endpackage

// ----- src/rss_divider.sv -----
// Iterative restoring remainder unit, one quotient bit per cycle.
// Depends on rss_pkg.
module rss_divider
    import rss_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int STEP_W = $clog2(RND_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [RND_W-1:0]  dvd_reg, dvd_next;
    logic [RND_W-1:0]  dsr_reg, dsr_next;
    logic [RND_W:0]    rem_reg, rem_next;
    logic [RND_W:0]    trial;

    assign trial = {rem_reg[RND_W-1:0], dvd_reg[RND_W-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (req.start) begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            dvd_next = dvd_reg << 1;
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = trial - {1'b0, dsr_reg};
            end else begin
                rem_next = trial;
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(RND_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg[RND_W-1:0];

endmodule

// ----- src/rss_min_scan.sv -----
// Compare unit for the flush: tracks the smallest (timestamp, id, slot)
// above the last beat sent. Depends on rss_pkg.
module rss_min_scan
    import rss_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  scan_ctrl_t         ctrl,
    input  logic [FIELD_W-1:0] cand_ts,
    input  logic [FIELD_W-1:0] cand_id,
    input  logic [FIELD_W-1:0] cand_pl,
    output logic               best_valid,
    output logic [FIELD_W-1:0] best_ts,
    output logic [FIELD_W-1:0] best_id,
    output logic [FIELD_W-1:0] best_pl,
    output logic [IDX_W-1:0]   best_idx
);

    localparam int KEY_W = 2 * FIELD_W + IDX_W;

    logic               valid_reg, valid_next;
    logic [FIELD_W-1:0] ts_reg, id_reg, pl_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [KEY_W-1:0]   cand_key, prev_key, best_key;
    logic               take;

    assign cand_key = {cand_ts, cand_id, ctrl.cand_idx};
    assign prev_key = {ctrl.prev_ts, ctrl.prev_id, ctrl.prev_idx};
    assign best_key = {ts_reg, id_reg, idx_reg};

    // slot index breaks ties, so of equal keys the lower slot wins
    assign take = ctrl.cand_valid
               && (!ctrl.prev_valid || cand_key > prev_key)
               && (!valid_reg || cand_key < best_key);

    always_comb begin
        valid_next = valid_reg;
        if (ctrl.clear) begin
            valid_next = 1'b0;
        end else if (take) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (take && !ctrl.clear) begin
            ts_reg  <= cand_ts;
            id_reg  <= cand_id;
            pl_reg  <= cand_pl;
            idx_reg <= ctrl.cand_idx;
        end
    end

    assign best_valid = valid_reg;
    assign best_ts    = ts_reg;
    assign best_id    = id_reg;
    assign best_pl    = pl_reg;
    assign best_idx   = idx_reg;

endmodule

// ----- src/reservoir_sampler_sorted_flush.sv -----
// Top level of the reservoir sampler: sequencer, slot memory, APB register.
// Depends on rss_pkg, rss_divider and rss_min_scan.
//
// Usage: data samples and flush markers enter on the s_ channel (valid/ready).
// A data sample while the reservoir has room is taken and written to the
// next slot. Once full, the slot is picked as random_value modulo the count
// of samples seen since the last flush, computed by the divider, and the
// sample is written only if the pick is below the size (random_value is used
// directly when the count exceeds 32 bits; a zero size register drops it).
// A flush sends the held entries on the m_ channel in ascending
// (timestamp, series_id) order, equal keys in slot order, the final beat
// with m_last_of_run set. Each beat needs one scan of the n held slots
// through the one read port of the memory and one comparator. s_ready stays
// low until the last beat is taken; a stalled receiver simply holds the block
// in that beat. reservoir_size is written over APB at address 0 (reset 32,
// saturated to the depth). Reset empties the reservoir and clears the
// counters; the slot memory itself is not cleared and is only read below the
// fill count.
module reservoir_sampler_sorted_flush
    import rss_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_is_flush,
    input  logic [FIELD_W-1:0] s_timestamp,
    input  logic [FIELD_W-1:0] s_series_id,
    input  logic [FIELD_W-1:0] s_payload_bits,
    input  logic [RND_W-1:0]   s_random_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [FIELD_W-1:0] m_out_timestamp,
    output logic [FIELD_W-1:0] m_out_series_id,
    output logic [FIELD_W-1:0] m_out_payload_bits,
    output logic               m_last_of_run
);

    localparam int ENTRY_W = 3 * FIELD_W;

    rss_state_t         state_reg, state_next;
    logic [SIZE_W-1:0]  size_reg;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [FIELD_W-1:0] seen_reg, seen_next, seen_inc;
    logic [CNT_W-1:0]   emit_reg, emit_next;
    logic [IDX_W-1:0]   addr_reg, addr_next;
    logic               rd_pend_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [FIELD_W-1:0] ts_reg, id_reg, pl_reg;
    logic [RND_W-1:0]   rnd_reg;
    logic [RND_W-1:0]   pick_reg, pick_next;
    logic               prev_valid_reg;
    logic [FIELD_W-1:0] prev_ts_reg, prev_id_reg;
    logic [IDX_W-1:0]   prev_idx_reg;
    logic               m_valid_reg;
    logic [FIELD_W-1:0] o_ts_reg, o_id_reg, o_pl_reg;
    logic               o_last_reg;

    logic [ENTRY_W-1:0] mem [RESERVOIR_DEPTH];
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic               rd_issue;

    logic [CNT_W-1:0]   eff_size;
    logic               s_fire, m_fire, cfg_wr;
    div_req_t           div_req;
    div_rsp_t           div_rsp;
    scan_ctrl_t         scan_ctrl;
    logic               best_valid;
    logic [FIELD_W-1:0] best_ts, best_id, best_pl;
    logic [IDX_W-1:0]   best_idx;

    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;
    assign cfg_wr = psel && penable && pwrite && pready;

    assign eff_size = ({1'b0, size_reg} > 7'(RESERVOIR_DEPTH))
                    ? CNT_W'(RESERVOIR_DEPTH) : CNT_W'(size_reg);
    assign seen_inc = (seen_reg == '1) ? seen_reg : seen_reg + FIELD_W'(1);

    // APB register
    assign pready = 1'b1;
    assign prdata = (paddr == REG_RESERVOIR_SIZE) ? DATA_W'(size_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_RESET;
        end else if (cfg_wr && paddr == REG_RESERVOIR_SIZE) begin
            size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_is_flush) begin
                        if (fill_reg != '0) state_next = ST_SCAN;
                    end else if (fill_reg < eff_size || eff_size == '0) begin
                        state_next = ST_IDLE;
                    end else if (seen_inc[FIELD_W-1:RND_W] != '0) begin
                        state_next = ST_PICK;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:      if (div_rsp.done) state_next = ST_PICK;
            ST_PICK:     state_next = ST_IDLE;
            ST_SCAN:     if (addr_reg == IDX_W'(fill_reg - CNT_W'(1))) state_next = ST_SCAN_END;
            ST_SCAN_END: state_next = ST_LOAD;
            ST_LOAD:     state_next = ST_OUT;
            ST_OUT: begin
                if (m_fire) begin
                    state_next = o_last_reg ? ST_IDLE : ST_SCAN;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        fill_next = fill_reg;
        seen_next = seen_reg;
        emit_next = emit_reg;
        addr_next = addr_reg;
        pick_next = pick_reg;
        we        = 1'b0;
        waddr     = fill_reg[IDX_W-1:0];
        rd_issue  = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = s_random_value;
        div_req.divisor  = seen_inc[RND_W-1:0];
        scan_ctrl.clear      = 1'b0;
        scan_ctrl.cand_valid = rd_pend_reg;
        scan_ctrl.cand_idx   = rd_idx_reg;
        scan_ctrl.prev_valid = prev_valid_reg;
        scan_ctrl.prev_ts    = prev_ts_reg;
        scan_ctrl.prev_id    = prev_id_reg;
        scan_ctrl.prev_idx   = prev_idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_is_flush) begin
                        emit_next = '0;
                        addr_next = '0;
                        scan_ctrl.clear = 1'b1;
                        if (fill_reg == '0) seen_next = '0;
                    end else begin
                        seen_next = seen_inc;
                        pick_next = s_random_value;
                        if (fill_reg < eff_size) begin
                            we        = 1'b1;
                            fill_next = fill_reg + CNT_W'(1);
                        end else if (eff_size != '0
                                     && seen_inc[FIELD_W-1:RND_W] == '0) begin
                            div_req.start = 1'b1;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_rsp.done) pick_next = div_rsp.remainder;
            end
            ST_PICK: begin
                waddr = pick_reg[IDX_W-1:0];
                we    = pick_reg < RND_W'(eff_size);
            end
            ST_SCAN: begin
                rd_issue  = 1'b1;
                addr_next = addr_reg + IDX_W'(1);
            end
            ST_LOAD: begin
                scan_ctrl.clear = 1'b1;
            end
            ST_OUT: begin
                if (m_fire) begin
                    emit_next = emit_reg + CNT_W'(1);
                    addr_next = '0;
                    if (o_last_reg) begin
                        fill_next = '0;
                        seen_next = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= (state_reg == ST_PICK) ? {ts_reg, id_reg, pl_reg}
                                                 : {s_timestamp, s_series_id, s_payload_bits};
        end
        rd_data_reg <= mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            seen_reg       <= '0;
            emit_reg       <= '0;
            addr_reg       <= '0;
            rd_pend_reg    <= 1'b0;
            prev_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            seen_reg    <= seen_next;
            emit_reg    <= emit_next;
            addr_reg    <= addr_next;
            rd_pend_reg <= rd_issue;
            if (s_fire && s_is_flush) begin
                prev_valid_reg <= 1'b0;
            end else if (state_reg == ST_LOAD) begin
                prev_valid_reg <= 1'b1;
            end
            if (state_reg == ST_LOAD) begin
                m_valid_reg <= 1'b1;
            end else if (m_fire) begin
                m_valid_reg <= 1'b0;
            end
        end
        rd_idx_reg <= addr_reg;
        pick_reg   <= pick_next;
        if (s_fire) begin
            ts_reg  <= s_timestamp;
            id_reg  <= s_series_id;
            pl_reg  <= s_payload_bits;
            rnd_reg <= s_random_value;
        end
        if (state_reg == ST_LOAD) begin
            prev_ts_reg  <= best_ts;
            prev_id_reg  <= best_id;
            prev_idx_reg <= best_idx;
            o_ts_reg     <= best_ts;
            o_id_reg     <= best_id;
            o_pl_reg     <= best_pl;
            o_last_reg   <= (emit_reg + CNT_W'(1)) == fill_reg;
        end
    end

    rss_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    rss_min_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (scan_ctrl),
        .cand_ts    (rd_data_reg[ENTRY_W-1 -: FIELD_W]),
        .cand_id    (rd_data_reg[2*FIELD_W-1 -: FIELD_W]),
        .cand_pl    (rd_data_reg[FIELD_W-1:0]),
        .best_valid (best_valid),
        .best_ts    (best_ts),
        .best_id    (best_id),
        .best_pl    (best_pl),
        .best_idx   (best_idx)
    );

    assign s_ready            = (state_reg == ST_IDLE);
    assign m_valid            = m_valid_reg;
    assign m_out_timestamp    = o_ts_reg;
    assign m_out_series_id    = o_id_reg;
    assign m_out_payload_bits = o_pl_reg;
    assign m_last_of_run      = o_last_reg;

    // the held count never exceeds the memory depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(RESERVOIR_DEPTH))
        else $error("fill count beyond depth");

    // a beat is only offered while the sequencer waits on the receiver
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (state_reg == ST_OUT && !s_ready))
        else $error("result beat outside output state");

    // every scan ends with a candidate found before it is loaded
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |-> best_valid)
        else $error("scan finished without a candidate");

    // when the divider is bypassed, the slot pick must match the random word as taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PICK && $past(state_reg) == ST_IDLE) |-> pick_reg == rnd_reg)
        else $error("slot pick lost the random word");

endmodule
